// ----- rtl/imhpq_pkg.sv -----
// Shared types and codes of the indexed min-heap priority queue.
package imhpq_pkg;

  localparam int unsigned IdBits      = 6;
  localparam int unsigned NumIds      = 64;
  localparam int unsigned KeyPortBits = 32;
  localparam int unsigned CountBits   = 7;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_UPDATE = 3'd2;
  localparam logic [2:0] OP_ERASE  = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_PEEK   = 3'd5;

  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_FULL        = 3'd1;
  localparam logic [2:0] STATUS_EMPTY       = 3'd2;
  localparam logic [2:0] STATUS_NOT_PRESENT = 3'd3;
  localparam logic [2:0] STATUS_PRESENT     = 3'd4;

  typedef struct packed {
    logic [2:0]             op;
    logic [IdBits-1:0]      elem_id;
    logic [KeyPortBits-1:0] key;
  } req_t;

  typedef struct packed {
    logic [2:0]             status;
    logic                   popped_valid;
    logic [IdBits-1:0]      popped_id;
    logic [KeyPortBits-1:0] popped_key;
    logic [IdBits-1:0]      top_id;
    logic [KeyPortBits-1:0] top_key;
    logic                   is_empty;
    logic [CountBits-1:0]   count;
  } rsp_t;

endpackage

// ----- rtl/imhpq_slot_ram.sv -----
// Heap slot memory: one write port, two registered read ports.
module imhpq_slot_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 38
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ----- rtl/indexed_min_heap_priority_queue_core.sv -----
// Top level of the indexed binary min-heap priority queue.
//
// Usage: one request on the input channel (op, elem_id, key) yields exactly one
// response on the output channel (status, popped element, root and count after
// the operation). Requests are taken one at a time; in_ready_o is high only
// while the sequencer is idle.
// Clear, peek and rejected requests go straight to the response. Push walks
// up the heap level by level; pop, erase and update read the last slot or the
// position table first and then sift level by level. Each move is made by the
// single read-compare-write loop over the slot memory, whose reads are
// registered.
// Reset: the heap is empty and no identifier is present; slot and position
// memories are not cleared, since only live entries are ever read.
// Stall: the response waits in an output register; the next request is taken
// meanwhile, and its result is held in the sequencer until the register frees.
module indexed_min_heap_priority_queue_core #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  imhpq_pkg::req_t    in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output imhpq_pkg::rsp_t    out_rsp_o
);

  localparam int unsigned KW = (KEY_BITS < imhpq_pkg::KeyPortBits) ?
                               KEY_BITS : imhpq_pkg::KeyPortBits;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = imhpq_pkg::IdBits;
  localparam int unsigned SW = IW + KW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POS_RD, ST_POS_CHK, ST_LAST_RD, ST_LAST_CHK,
    ST_UP_RD, ST_UP_CHK, ST_DN_RD, ST_DN_CHK, ST_FIN
  } state_e;

  state_e                     state_q;
  logic [2:0]                 op_q;
  logic [IW-1:0]              id_q;
  logic [KW-1:0]              key_q;
  logic [AW-1:0]              hole_q;
  logic [CW-1:0]              count_q;
  logic                       settle_q;   // settle: try up first, then down
  logic                       first_q;    // no up move made yet
  logic [2:0]                 status_q;
  logic                       pop_v_q;
  logic [IW-1:0]              pop_id_q;
  logic [KW-1:0]              pop_key_q;
  logic [IW-1:0]              root_id_q;
  logic [KW-1:0]              root_key_q;
  logic [imhpq_pkg::NumIds-1:0] present_q;
  logic                       out_valid_q;
  imhpq_pkg::rsp_t            out_rsp_q;

  // position table
  logic [AW-1:0] pos_mem [imhpq_pkg::NumIds];
  logic [AW-1:0] pos_rdata_q;

  // slot memory ports
  logic          heap_we;
  logic [AW-1:0] heap_waddr;
  logic [SW-1:0] heap_wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  logic [SW-1:0] rdata_a;
  logic [SW-1:0] rdata_b;

  logic [AW-1:0] parent;
  logic [CW:0]   child;
  logic [CW:0]   child_m1;
  logic          dn_end;
  logic          par_gt;
  logic          pick_a;
  logic [SW-1:0] pick;
  logic [AW-1:0] pick_slot;
  logic          dn_move;
  logic          up_only;
  logic          rsp_load;

  imhpq_slot_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (SW)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .we_i      (heap_we),
    .waddr_i   (heap_waddr),
    .wdata_i   (heap_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Tree arithmetic around the current hole.
  assign parent   = AW'((hole_q - AW'(1)) >> 1);
  assign child    = ((CW+1)'(hole_q) << 1) + (CW+1)'(2);
  assign child_m1 = child - (CW+1)'(1);
  assign dn_end   = child > {1'b0, count_q};
  assign par_gt   = rdata_a[KW-1:0] > key_q;
  // Take the left child when the right one is missing or strictly greater.
  assign pick_a    = (child == {1'b0, count_q}) || (rdata_b[KW-1:0] > rdata_a[KW-1:0]);
  assign pick      = pick_a ? rdata_a : rdata_b;
  assign pick_slot = pick_a ? AW'(child_m1) : AW'(child);
  assign dn_move   = key_q > pick[KW-1:0];
  assign up_only   = !(settle_q && first_q);

  // Load the output register once the result is ready and the register frees.
  assign rsp_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  assign raddr_a = (state_q == ST_LAST_RD) ? AW'(count_q) :
                   (state_q == ST_UP_RD)   ? parent : AW'(child_m1);
  assign raddr_b = AW'(child);

  // Place an element at the hole; the position table follows every slot write.
  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = hole_q;
    heap_wdata = {id_q, key_q};
    unique case (state_q)
      ST_UP_RD:  heap_we = (hole_q == '0) && up_only;
      ST_UP_CHK: begin
        if (par_gt) begin
          heap_we    = 1'b1;
          heap_wdata = rdata_a;
        end else begin
          heap_we = up_only;
        end
      end
      ST_DN_RD:  heap_we = dn_end;
      ST_DN_CHK: begin
        heap_we = 1'b1;
        if (dn_move) begin
          heap_wdata = pick;
        end
      end
      default: heap_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      pos_mem[heap_wdata[SW-1:KW]] <= heap_waddr;
    end
    pos_rdata_q <= pos_mem[id_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rsp_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (heap_we && heap_waddr == '0) begin
        root_id_q  <= heap_wdata[SW-1:KW];
        root_key_q <= heap_wdata[KW-1:0];
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q    <= in_req_i.op;
            id_q    <= in_req_i.elem_id;
            key_q   <= in_req_i.key[KW-1:0];
            pop_v_q <= 1'b0;
            unique case (in_req_i.op) inside
              imhpq_pkg::OP_PUSH, imhpq_pkg::OP_UPDATE: begin
                if (in_req_i.op == imhpq_pkg::OP_UPDATE &&
                    present_q[in_req_i.elem_id]) begin
                  status_q <= imhpq_pkg::STATUS_OK;
                  state_q  <= ST_POS_RD;
                end else if (count_q == CW'(CAPACITY)) begin
                  status_q <= imhpq_pkg::STATUS_FULL;
                  state_q  <= ST_FIN;
                end else if (present_q[in_req_i.elem_id]) begin
                  status_q <= imhpq_pkg::STATUS_PRESENT;
                  state_q  <= ST_FIN;
                end else begin
                  status_q <= imhpq_pkg::STATUS_OK;
                  present_q[in_req_i.elem_id] <= 1'b1;
                  hole_q   <= AW'(count_q);
                  count_q  <= count_q + CW'(1);
                  settle_q <= 1'b0;
                  first_q  <= 1'b1;
                  state_q  <= ST_UP_RD;
                end
              end
              imhpq_pkg::OP_POP: begin
                if (count_q == '0) begin
                  status_q <= imhpq_pkg::STATUS_EMPTY;
                  state_q  <= ST_FIN;
                end else begin
                  status_q             <= imhpq_pkg::STATUS_OK;
                  pop_v_q              <= 1'b1;
                  pop_id_q             <= root_id_q;
                  pop_key_q            <= root_key_q;
                  present_q[root_id_q] <= 1'b0;
                  count_q              <= count_q - CW'(1);
                  hole_q               <= '0;
                  state_q              <= ST_LAST_RD;
                end
              end
              imhpq_pkg::OP_ERASE: begin
                if (!present_q[in_req_i.elem_id]) begin
                  status_q <= imhpq_pkg::STATUS_NOT_PRESENT;
                  state_q  <= ST_FIN;
                end else begin
                  status_q <= imhpq_pkg::STATUS_OK;
                  present_q[in_req_i.elem_id] <= 1'b0;
                  state_q <= ST_POS_RD;
                end
              end
              imhpq_pkg::OP_CLEAR: begin
                status_q  <= imhpq_pkg::STATUS_OK;
                count_q   <= '0;
                present_q <= '0;
                state_q   <= ST_FIN;
              end
              imhpq_pkg::OP_PEEK: begin
                status_q <= (count_q == '0) ? imhpq_pkg::STATUS_EMPTY :
                                              imhpq_pkg::STATUS_OK;
                state_q  <= ST_FIN;
              end
              default: begin
                status_q <= imhpq_pkg::STATUS_OK;
                state_q  <= ST_FIN;
              end
            endcase
          end
        end
        ST_POS_RD: state_q <= ST_POS_CHK;
        ST_POS_CHK: begin
          if ((CW+1)'(pos_rdata_q) < (CW+1)'(count_q)) begin
            hole_q <= pos_rdata_q;
            if (op_q == imhpq_pkg::OP_UPDATE) begin
              settle_q <= 1'b1;
              first_q  <= 1'b1;
              state_q  <= ST_UP_RD;
            end else begin
              count_q <= count_q - CW'(1);
              state_q <= ST_LAST_RD;
            end
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_LAST_RD: state_q <= ST_LAST_CHK;
        ST_LAST_CHK: begin
          id_q     <= rdata_a[SW-1:KW];
          key_q    <= rdata_a[KW-1:0];
          settle_q <= 1'b1;
          first_q  <= 1'b1;
          state_q  <= ST_UP_RD;
        end
        ST_UP_RD: begin
          if (hole_q != '0) begin
            state_q <= ST_UP_CHK;
          end else if (up_only) begin
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_DN_RD;
          end
        end
        ST_UP_CHK: begin
          if (par_gt) begin
            hole_q  <= parent;
            first_q <= 1'b0;
            state_q <= ST_UP_RD;
          end else if (up_only) begin
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_DN_RD;
          end
        end
        ST_DN_RD: state_q <= dn_end ? ST_FIN : ST_DN_CHK;
        ST_DN_CHK: begin
          if (dn_move) begin
            hole_q  <= pick_slot;
            state_q <= ST_DN_RD;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          // Hold the result until the output register frees.
          if (rsp_load) begin
            out_rsp_q.status       <= status_q;
            out_rsp_q.popped_valid <= pop_v_q;
            out_rsp_q.popped_id    <= pop_v_q ? pop_id_q : '0;
            out_rsp_q.popped_key   <= pop_v_q ? imhpq_pkg::KeyPortBits'(pop_key_q) : '0;
            out_rsp_q.top_id       <= (count_q != '0) ? root_id_q : '0;
            out_rsp_q.top_key      <= (count_q != '0) ?
                                      imhpq_pkg::KeyPortBits'(root_key_q) : '0;
            out_rsp_q.is_empty     <= (count_q == '0);
            out_rsp_q.count        <= imhpq_pkg::CountBits'(count_q);
            state_q                <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ----- rtl/imhpq_checker.sv -----
// Port-level checks of the heap queue and their binding to the top level.
module imhpq_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input imhpq_pkg::req_t in_req_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input imhpq_pkg::rsp_t out_rsp_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed while stalled");

  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.popped_valid |->
      out_rsp_o.status == imhpq_pkg::STATUS_OK)
    else $error("pop reported with error status");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.is_empty == (out_rsp_o.count == '0))
    else $error("empty flag disagrees with count");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.is_empty |->
      out_rsp_o.top_id == '0 && out_rsp_o.top_key == '0)
    else $error("root shown on empty heap");

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_req_i.op == imhpq_pkg::OP_PEEK |=> !in_ready_o)
    else $error("request taken while previous one in flight");

endmodule

bind indexed_min_heap_priority_queue_core imhpq_checker u_imhpq_checker (.*);
